### rtl/core/lpf_pkg.sv
// Shared types, codes and the dimming-curve builder for the LED PWM fade controller.
// Used by lpf_muldiv, led_pwm_fade_controller_unit and the testbench; depends on nothing else.
`default_nettype none

package lpf_pkg;

  // Width of the fade timer, the elapsed count and the fade-time register.
  localparam int TIME_W = 16;

  // Widest duty value the curve table can hold (resolution of up to 16 bits plus one).
  localparam int CURVE_W = 17;

  // Configuration register indexes.
  localparam logic [0:0] CFG_FADE_TIME = 1'b0;
  localparam logic [0:0] CFG_INVERT    = 1'b1;

  // Item kinds.
  localparam logic FUNC_LEVEL = 1'b0;
  localparam logic FUNC_TICK  = 1'b1;

  // Decimal fixed point with eighteen fraction digits.
  localparam logic [63:0] ONE_E9     = 64'd1000000000;
  localparam logic [63:0] ONE_E18    = 64'd1000000000000000000;
  localparam logic [63:0] STEP_RATIO = 64'd987415635746865696;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LEVEL,
    S_TICK,
    S_CALC,
    S_DONE
  } state_t;

  typedef logic [CURVE_W-1:0] curve_tab_t [0:255];

  // Product of two eighteen-digit fractions, truncated. Only used at elaboration.
  function automatic logic [63:0] fx_mul(input logic [63:0] x, input logic [63:0] y);
    logic [63:0] xh, xl, yh, yl, mid, low;
    xh  = x / ONE_E9;
    xl  = x % ONE_E9;
    yh  = y / ONE_E9;
    yl  = y % ONE_E9;
    mid = xh * yl + xl * yh;
    low = (xl * yl) / ONE_E9;
    return xh * yh + (mid + low) / ONE_E9;
  endfunction

  // Builds the whole brightness-to-duty table. The power of the step ratio is
  // carried down from full brightness one product at a time, as each entry
  // needs one more factor than the one above it.
  function automatic curve_tab_t build_curve(input int res_bits);
    curve_tab_t  tab;
    logic [63:0] v, vh, vl, q, t, full;
    int          b;
    full   = 64'd1 << res_bits;
    v      = ONE_E18;
    tab[0] = '0;
    for (int k = 0; k < 255; k++) begin
      b      = 255 - k;
      vh     = v / ONE_E9;
      vl     = v % ONE_E9;
      q      = full * vh;
      t      = full * vl + ONE_E18 / 64'd2;
      tab[b] = CURVE_W'((q + t / ONE_E9) / ONE_E9);
      v      = fx_mul(v, STEP_RATIO);
    end
    return tab;
  endfunction

endpackage

`default_nettype wire

### rtl/core/lpf_muldiv.sv
// Bit-serial unit that forms (mag * mult) / divisor, truncated, for the fade ramp.
// Uses lpf_pkg for the timer width; instantiated by led_pwm_fade_controller_unit.
`default_nettype none

module lpf_muldiv #(
  parameter int DUTY_W = 13
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [DUTY_W-1:0]         mag,
  input  wire logic [lpf_pkg::TIME_W-1:0] mult,
  input  wire logic [lpf_pkg::TIME_W-1:0] divisor,
  output logic                           done,
  output logic [DUTY_W-1:0]              quot
);

  localparam int TW    = lpf_pkg::TIME_W;
  localparam int PW    = DUTY_W + TW;
  localparam int STEPS = (DUTY_W > TW) ? DUTY_W : TW;
  localparam int CW    = $clog2(STEPS + 1);

  logic              busy_r, busy_nxt;
  logic              div_r, div_nxt;
  logic              done_r, done_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [PW-1:0]     p_r, p_nxt;
  logic [DUTY_W-1:0] mag_r, mag_nxt;
  logic [TW-1:0]     dvs_r, dvs_nxt;

  logic [DUTY_W:0]   mul_sum;
  logic [TW-1:0]     rem;
  logic [TW+1:0]     trial;
  logic              q_bit;
  logic [TW-1:0]     rem_new;

  // One register holds the product while it is built (high half accumulates,
  // low half shifts the multiplier out), then the partial remainder above the
  // quotient bits while the division runs.
  always_comb begin
    mul_sum = {1'b0, p_r[PW-1:TW]} + (p_r[0] ? {1'b0, mag_r} : '0);
    rem     = p_r[PW-1:DUTY_W];
    trial   = {1'b0, rem, p_r[DUTY_W-1]} - {2'b00, dvs_r};
    q_bit   = ~trial[TW+1];
    rem_new = q_bit ? trial[TW-1:0] : {rem[TW-2:0], p_r[DUTY_W-1]};
  end

  always_comb begin
    busy_nxt = busy_r;
    div_nxt  = div_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    p_nxt    = p_r;
    mag_nxt  = mag_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      div_nxt  = 1'b0;
      cnt_nxt  = '0;
      p_nxt    = {{DUTY_W{1'b0}}, mult};
      mag_nxt  = mag;
      dvs_nxt  = divisor;
    end else if (busy_r && !div_r) begin
      p_nxt = {mul_sum, p_r[TW-1:1]};
      if (cnt_r == CW'(TW - 1)) begin
        div_nxt = 1'b1;
        cnt_nxt = '0;
      end else begin
        cnt_nxt = cnt_r + CW'(1);
      end
    end else if (busy_r) begin
      // The quotient is below mag, so the top bits alone start below the divisor.
      p_nxt = {rem_new, p_r[DUTY_W-2:0], q_bit};
      if (cnt_r == CW'(DUTY_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      div_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      div_r  <= div_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_r   <= p_nxt;
    mag_r <= mag_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done = done_r;
  assign quot = p_r[DUTY_W-1:0];

endmodule

`default_nettype wire

### rtl/core/led_pwm_fade_controller_unit.sv
// LED PWM fade controller: one item in, one result beat out, at most one item at a time.
// A level item passes through S_LEVEL and S_DONE. A tick with no fade running, or one on
// which the fade ends, passes through S_TICK and S_DONE. A tick inside a fade passes through
// S_TICK, then waits in S_CALC for the ramp point, then S_DONE. In every case the result
// beat is presented in the same cycle as the input reopens. The ramp point comes from the
// bit-serial unit lpf_muldiv: sixteen shift-add steps, then one restoring division step per
// duty bit (PWM_RESOLUTION_BITS + 1). A stalled result beat holds the next result in S_DONE
// until it is taken. Brightness maps to duty through a 256-entry constant table built at
// elaboration. Configuration is taken at any time and is always ready. Depends on lpf_pkg
// and lpf_muldiv.
`default_nettype none

module led_pwm_fade_controller_unit #(
  parameter int PWM_RESOLUTION_BITS = 12
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic                           in_func,
  input  wire logic                           in_led_on,
  input  wire logic [7:0]                     in_brightness,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [PWM_RESOLUTION_BITS:0]        out_duty,
  output logic                                out_fading,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [0:0]                     cfg_index,
  input  wire logic [lpf_pkg::TIME_W-1:0]     cfg_wdata
);

  localparam int DW = PWM_RESOLUTION_BITS + 1;
  localparam int TW = lpf_pkg::TIME_W;
  localparam logic [DW-1:0] FULL_SCALE = {1'b1, {PWM_RESOLUTION_BITS{1'b0}}};
  localparam lpf_pkg::curve_tab_t CURVE = lpf_pkg::build_curve(PWM_RESOLUTION_BITS);

  lpf_pkg::state_t state_r, state_nxt;

  logic [TW-1:0] ft_r;
  logic          inv_r;
  logic          init_r, init_nxt;
  logic          fade_r, fade_nxt;
  logic [DW-1:0] start_r, start_nxt;
  logic [DW-1:0] target_r, target_nxt;
  logic [DW-1:0] cur_r, cur_nxt;
  logic [TW-1:0] elapsed_r, elapsed_nxt;

  logic          on_r;
  logic [7:0]    bright_r;

  logic          out_valid_r;
  logic [DW-1:0] out_duty_r;
  logic          out_fading_r;

  logic          in_take;
  logic          out_free;
  logic          out_load;
  logic          md_start;
  logic          md_done;
  logic [DW-1:0] md_quot;

  logic [7:0]    lvl_idx;
  logic [DW-1:0] lvl_curve;
  logic [DW-1:0] lvl_t;
  logic [TW-1:0] el_inc;
  logic          tick_done;
  logic          ramp_down;
  logic [DW-1:0] ramp_mag;

  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    lvl_idx   = on_r ? bright_r : 8'd0;
    lvl_curve = CURVE[lvl_idx][DW-1:0];
    lvl_t     = inv_r ? (FULL_SCALE - lvl_curve) : lvl_curve;
    el_inc    = (elapsed_r != {TW{1'b1}}) ? (elapsed_r + TW'(1)) : elapsed_r;
    tick_done = !fade_r || (el_inc >= ft_r);
    ramp_down = target_r < start_r;
    ramp_mag  = ramp_down ? (start_r - target_r) : (target_r - start_r);
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lpf_pkg::S_IDLE: begin
        if (in_take) begin
          state_nxt = (in_func == lpf_pkg::FUNC_TICK) ? lpf_pkg::S_TICK : lpf_pkg::S_LEVEL;
        end
      end
      lpf_pkg::S_LEVEL: state_nxt = lpf_pkg::S_DONE;
      lpf_pkg::S_TICK:  state_nxt = tick_done ? lpf_pkg::S_DONE : lpf_pkg::S_CALC;
      lpf_pkg::S_CALC: begin
        if (md_done) begin
          state_nxt = lpf_pkg::S_DONE;
        end
      end
      lpf_pkg::S_DONE: begin
        if (out_free) begin
          state_nxt = lpf_pkg::S_IDLE;
        end
      end
      default: state_nxt = lpf_pkg::S_IDLE;
    endcase
  end

  // Control outputs of the sequencer
  always_comb begin
    in_stall = 1'b1;
    md_start = 1'b0;
    out_load = 1'b0;
    case (state_r)
      lpf_pkg::S_IDLE:  in_stall = 1'b0;
      lpf_pkg::S_TICK:  md_start = !tick_done;
      lpf_pkg::S_DONE:  out_load = out_free;
      default: ;
    endcase
  end

  // Fade state updates
  always_comb begin
    init_nxt    = init_r;
    fade_nxt    = fade_r;
    start_nxt   = start_r;
    target_nxt  = target_r;
    cur_nxt     = cur_r;
    elapsed_nxt = elapsed_r;
    case (state_r)
      lpf_pkg::S_LEVEL: begin
        if (!init_r || (ft_r == '0 && !(lvl_t == target_r && !fade_r))) begin
          // First level after reset, or a jump with no fade time.
          init_nxt   = 1'b1;
          cur_nxt    = lvl_t;
          start_nxt  = lvl_t;
          target_nxt = lvl_t;
          fade_nxt   = 1'b0;
        end else if (!(lvl_t == target_r && !fade_r)) begin
          start_nxt   = cur_r;
          target_nxt  = lvl_t;
          elapsed_nxt = '0;
          fade_nxt    = 1'b1;
        end
      end
      lpf_pkg::S_TICK: begin
        if (fade_r) begin
          elapsed_nxt = el_inc;
          if (el_inc >= ft_r) begin
            cur_nxt  = target_r;
            fade_nxt = 1'b0;
          end
        end
      end
      lpf_pkg::S_CALC: begin
        // The ramp point lies between start and target, so no clamping is needed.
        if (md_done) begin
          cur_nxt = ramp_down ? (start_r - md_quot) : (start_r + md_quot);
        end
      end
      default: ;
    endcase
  end

  lpf_muldiv #(
    .DUTY_W (DW)
  ) u_muldiv (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (md_start),
    .mag     (ramp_mag),
    .mult    (el_inc),
    .divisor (ft_r),
    .done    (md_done),
    .quot    (md_quot)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lpf_pkg::S_IDLE;
      ft_r        <= '0;
      inv_r       <= 1'b0;
      init_r      <= 1'b0;
      fade_r      <= 1'b0;
      start_r     <= '0;
      target_r    <= '0;
      cur_r       <= '0;
      elapsed_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      init_r    <= init_nxt;
      fade_r    <= fade_nxt;
      start_r   <= start_nxt;
      target_r  <= target_nxt;
      cur_r     <= cur_nxt;
      elapsed_r <= elapsed_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          lpf_pkg::CFG_FADE_TIME: ft_r  <= cfg_wdata;
          lpf_pkg::CFG_INVERT:    inv_r <= cfg_wdata[0];
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      on_r     <= in_led_on;
      bright_r <= in_brightness;
    end
    if (out_load) begin
      out_duty_r   <= cur_r;
      out_fading_r <= fade_r;
    end
  end

  assign cfg_ready  = 1'b1;
  assign out_valid  = out_valid_r;
  assign out_duty   = out_duty_r;
  assign out_fading = out_fading_r;

endmodule

`default_nettype wire

### rtl/core/lpf_checker.sv
// Port-level checks for led_pwm_fade_controller_unit, attached by the bind below.
// Depends on the top level's ports only.
`default_nettype none

module lpf_checker #(
  parameter int PWM_RESOLUTION_BITS = 12
) (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         in_valid,
  input wire logic                         in_stall,
  input wire logic                         out_valid,
  input wire logic                         out_stall,
  input wire logic [PWM_RESOLUTION_BITS:0] out_duty,
  input wire logic                         out_fading
);

  localparam logic [PWM_RESOLUTION_BITS:0] FULL_SCALE = {1'b1, {PWM_RESOLUTION_BITS{1'b0}}};

  // Reset empties the result register.
  a_reset_empties: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat present after reset");

  // A duty beyond full scale can never be produced.
  a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_duty <= FULL_SCALE)
    else $error("duty above full scale");

  // Only one item is in flight: taking a beat closes the input for the next cycle.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input open straight after a beat was taken");

  a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result beat withdrawn");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_duty) && $stable(out_fading))
    else $error("stalled result beat changed");

endmodule

bind led_pwm_fade_controller_unit lpf_checker #(
  .PWM_RESOLUTION_BITS (PWM_RESOLUTION_BITS)
) u_lpf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_duty   (out_duty),
  .out_fading (out_fading)
);

`default_nettype wire

### tb/testbench.sv
// Self-checking testbench for the LED PWM fade controller: directed steps, then random phases.
// Predicts each result beat from its own dimming-curve table and fade model, or takes it from the script's fixed value.
// Depends on lpf_pkg and the led_pwm_fade_controller_unit RTL.
`timescale 1ns / 100ps

module testbench;

  localparam int  RES_BITS    = 12;
  localparam int  DUTY_W      = RES_BITS + 1;
  localparam int  FULL_SCALE  = 1 << RES_BITS;
  localparam int  CYCLE_LIMIT = 1000000;
  localparam int  PHASES      = 8;
  localparam int  PHASE_ITEMS = 170;
  localparam logic [127:0] FIX_ONE  = 128'd1000000000000000000;
  localparam logic [127:0] FIX_STEP = 128'd987415635746865696;

  typedef struct packed {
    logic [DUTY_W-1:0] duty;
    logic              fading;
  } duty_beat_t;

  typedef struct packed {
    logic                       is_cfg;
    logic                       func;
    logic                       on;
    logic [7:0]                 bri;
    logic [0:0]                 idx;
    logic [lpf_pkg::TIME_W-1:0] wdata;
    logic                       fixed;
    logic [DUTY_W-1:0]          duty;
    logic                       fading;
  } script_row_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic                       in_func = lpf_pkg::FUNC_LEVEL;
  logic                       in_led_on = 1'b0;
  logic [7:0]                 in_brightness = 8'd0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [DUTY_W-1:0]          out_duty;
  logic                       out_fading;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [0:0]                 cfg_index = lpf_pkg::CFG_FADE_TIME;
  logic [lpf_pkg::TIME_W-1:0] cfg_wdata = '0;

  // Brightness-to-duty curve and the predicted block state.
  logic [DUTY_W-1:0]          dim_tab [0:255];
  logic [lpf_pkg::TIME_W-1:0] fade_len = '0;
  logic                       invert_sel = 1'b0;
  logic                       m_init = 1'b0;
  logic                       m_fading = 1'b0;
  logic [DUTY_W-1:0]          m_start = '0;
  logic [DUTY_W-1:0]          m_target = '0;
  logic [DUTY_W-1:0]          m_duty = '0;
  logic [lpf_pkg::TIME_W-1:0] m_elapsed = '0;

  duty_beat_t          pending_duty [$];
  script_row_t         script [$];

  logic                fixed_sel = 1'b0;
  logic [DUTY_W-1:0]   fixed_duty = '0;
  logic                fixed_fading = 1'b0;

  int                  errors = 0;
  int                  level_count = 0;
  int                  tick_count = 0;
  int                  beat_count = 0;
  int                  fade_ends = 0;
  int                  stall_pct = 0;
  int                  cycle_count = 0;

  led_pwm_fade_controller_unit #(.PWM_RESOLUTION_BITS(RES_BITS)) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_func       (in_func),
    .in_led_on     (in_led_on),
    .in_brightness (in_brightness),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_duty      (out_duty),
    .out_fading    (out_fading),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d beats outstanding",
               cycle_count, pending_duty.size());
      $display("FAIL");
      $finish;
    end
  end

  // The curve is carried down from full brightness, one truncated product per step.
  initial begin
    logic [127:0] pow;
    pow = FIX_ONE;
    dim_tab[0] = '0;
    for (int b = 255; b >= 1; b--) begin
      dim_tab[b] = DUTY_W'((FULL_SCALE * pow + FIX_ONE / 2) / FIX_ONE);
      pow = (pow * FIX_STEP) / FIX_ONE;
    end
  end

  always @(negedge clk) begin
    out_stall = ($urandom_range(99) < stall_pct);
  end

  // Checks result beats, tracks register writes and predicts each accepted item.
  always @(posedge clk) begin
    duty_beat_t        want;
    logic [DUTY_W-1:0] tgt;
    longint            ramp;
    if (out_valid && !out_stall) begin
      beat_count++;
      if (pending_duty.size() == 0) begin
        $error("result beat with nothing expected: duty %0d fading %0b", out_duty, out_fading);
        errors++;
      end else begin
        want = pending_duty.pop_front();
        if (out_duty !== want.duty) begin
          $error("duty mismatch: expected %0d, got %0d", want.duty, out_duty);
          errors++;
        end
        if (out_fading !== want.fading) begin
          $error("fading mismatch: expected %0b, got %0b", want.fading, out_fading);
          errors++;
        end
      end
    end
    if (cfg_valid && cfg_ready) begin
      if (cfg_index == lpf_pkg::CFG_FADE_TIME) fade_len = cfg_wdata;
      else invert_sel = cfg_wdata[0];
    end
    if (in_valid && !in_stall) begin
      if (in_func == lpf_pkg::FUNC_LEVEL) begin
        level_count++;
        tgt = dim_tab[in_led_on ? in_brightness : 8'd0];
        if (invert_sel) tgt = DUTY_W'(FULL_SCALE) - tgt;
        if (!m_init) begin
          m_init   = 1'b1;
          m_duty   = tgt;
          m_start  = tgt;
          m_target = tgt;
          m_fading = 1'b0;
        end else if (tgt != m_target || m_fading) begin
          if (fade_len == 0) begin
            m_duty   = tgt;
            m_start  = tgt;
            m_target = tgt;
            m_fading = 1'b0;
          end else begin
            // A repeated target during a fade still restarts it from here.
            m_start   = m_duty;
            m_target  = tgt;
            m_elapsed = '0;
            m_fading  = 1'b1;
          end
        end
      end else begin
        tick_count++;
        if (m_fading) begin
          if (m_elapsed != '1) m_elapsed++;
          if (m_elapsed >= fade_len) begin
            m_duty   = m_target;
            m_fading = 1'b0;
            fade_ends++;
          end else begin
            ramp = longint'(m_start) + ((longint'(m_target) - longint'(m_start)) *
                   longint'(m_elapsed)) / longint'(fade_len);
            if (ramp < 0) ramp = 0;
            if (ramp > FULL_SCALE) ramp = FULL_SCALE;
            m_duty = DUTY_W'(ramp);
          end
        end
      end
      want.duty   = fixed_sel ? fixed_duty : m_duty;
      want.fading = fixed_sel ? fixed_fading : m_fading;
      pending_duty.push_back(want);
    end
  end

  function automatic script_row_t item_row(logic func, logic on, logic [7:0] bri);
    script_row_t r;
    r = '0;
    r.func = func;
    r.on   = on;
    r.bri  = bri;
    return r;
  endfunction

  function automatic script_row_t fixed_row(logic func, logic on, logic [7:0] bri,
                                            int duty, logic fading);
    script_row_t r;
    r        = item_row(func, on, bri);
    r.fixed  = 1'b1;
    r.duty   = DUTY_W'(duty);
    r.fading = fading;
    return r;
  endfunction

  function automatic script_row_t reg_row(logic [0:0] idx, int wdata);
    script_row_t r;
    r        = '0;
    r.is_cfg = 1'b1;
    r.idx    = idx;
    r.wdata  = lpf_pkg::TIME_W'(wdata);
    return r;
  endfunction

  task automatic wait_drained();
    in_valid = 1'b0;
    while (pending_duty.size() != 0) @(negedge clk);
  endtask

  // Registers are only written once the block has handed back every beat.
  task automatic write_reg(logic [0:0] idx, logic [lpf_pkg::TIME_W-1:0] wdata);
    wait_drained();
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_wdata = wdata;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic send_item(logic func, logic on, logic [7:0] bri, logic fixed,
                           logic [DUTY_W-1:0] duty, logic fading, int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid      = 1'b1;
    in_func       = func;
    in_led_on     = on;
    in_brightness = bri;
    fixed_sel     = fixed;
    fixed_duty    = duty;
    fixed_fading  = fading;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    script_row_t r;
    int          idle_pct;
    int          len;
    logic [7:0]  bri;

    // Reset values first, then extremes, inversion and the fade corner cases.
    script.push_back(fixed_row(lpf_pkg::FUNC_TICK, 1'b1, 8'hFF, 0, 1'b0));
    script.push_back(fixed_row(lpf_pkg::FUNC_LEVEL, 1'b1, 8'd255, FULL_SCALE, 1'b0));
    script.push_back(fixed_row(lpf_pkg::FUNC_LEVEL, 1'b0, 8'd255, 0, 1'b0));
    script.push_back(fixed_row(lpf_pkg::FUNC_LEVEL, 1'b1, 8'd0, 0, 1'b0));
    script.push_back(item_row(lpf_pkg::FUNC_LEVEL, 1'b1, 8'd1));
    script.push_back(item_row(lpf_pkg::FUNC_LEVEL, 1'b1, 8'd254));
    script.push_back(item_row(lpf_pkg::FUNC_TICK, 1'b0, 8'h5A));
    script.push_back(reg_row(lpf_pkg::CFG_INVERT, 1));
    script.push_back(fixed_row(lpf_pkg::FUNC_LEVEL, 1'b1, 8'd255, 0, 1'b0));
    script.push_back(fixed_row(lpf_pkg::FUNC_LEVEL, 1'b0, 8'd0, FULL_SCALE, 1'b0));
    script.push_back(reg_row(lpf_pkg::CFG_INVERT, 0));
    script.push_back(reg_row(lpf_pkg::CFG_FADE_TIME, 4));
    script.push_back(fixed_row(lpf_pkg::FUNC_LEVEL, 1'b1, 8'd255, FULL_SCALE, 1'b0));
    script.push_back(fixed_row(lpf_pkg::FUNC_LEVEL, 1'b0, 8'd255, FULL_SCALE, 1'b1));
    for (int i = 0; i < 3; i++) script.push_back(item_row(lpf_pkg::FUNC_TICK, 1'b0, 8'd0));
    script.push_back(fixed_row(lpf_pkg::FUNC_TICK, 1'b1, 8'd7, 0, 1'b0));
    script.push_back(item_row(lpf_pkg::FUNC_LEVEL, 1'b1, 8'd200));
    script.push_back(item_row(lpf_pkg::FUNC_TICK, 1'b0, 8'd0));
    script.push_back(item_row(lpf_pkg::FUNC_LEVEL, 1'b1, 8'd200));
    script.push_back(reg_row(lpf_pkg::CFG_FADE_TIME, 10));
    script.push_back(item_row(lpf_pkg::FUNC_LEVEL, 1'b1, 8'd255));
    for (int i = 0; i < 3; i++) script.push_back(item_row(lpf_pkg::FUNC_TICK, 1'b1, 8'd0));
    // Shortening the fade below the time already spent ends it on the next tick.
    script.push_back(reg_row(lpf_pkg::CFG_FADE_TIME, 2));
    script.push_back(fixed_row(lpf_pkg::FUNC_TICK, 1'b0, 8'd0, FULL_SCALE, 1'b0));
    script.push_back(fixed_row(lpf_pkg::FUNC_LEVEL, 1'b0, 8'd128, FULL_SCALE, 1'b1));
    script.push_back(reg_row(lpf_pkg::CFG_FADE_TIME, 0));
    script.push_back(fixed_row(lpf_pkg::FUNC_TICK, 1'b0, 8'd0, 0, 1'b0));
    script.push_back(reg_row(lpf_pkg::CFG_FADE_TIME, 65535));
    script.push_back(item_row(lpf_pkg::FUNC_LEVEL, 1'b1, 8'd128));
    script.push_back(item_row(lpf_pkg::FUNC_TICK, 1'b0, 8'd0));

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (script[i]) begin
      r = script[i];
      if (r.is_cfg) write_reg(r.idx, r.wdata);
      else send_item(r.func, r.on, r.bri, r.fixed, r.duty, r.fading, 0);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       len = 0;
        1:       len = 1;
        2:       len = 3;
        3:       len = 65535;
        4:       len = $urandom_range(2, 40);
        5:       len = 7;
        6:       len = 0;
        default: len = $urandom_range(1, 20);
      endcase
      write_reg(lpf_pkg::CFG_FADE_TIME, lpf_pkg::TIME_W'(len));
      write_reg(lpf_pkg::CFG_INVERT, lpf_pkg::TIME_W'(ph % 3 == 1));
      case (ph % 4)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 68; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 68; end
        default: begin idle_pct = 32; stall_pct = 32; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n == PHASE_ITEMS / 2) wait_drained();
        // Mostly runs of ticks behind the odd level change, so fades run their course.
        if ($urandom_range(99) < (len == 0 ? 30 : 12)) begin
          case ($urandom_range(9))
            0:       bri = 8'd0;
            1:       bri = 8'd255;
            default: bri = 8'($urandom_range(255));
          endcase
          send_item(lpf_pkg::FUNC_LEVEL, ($urandom_range(99) < 85), bri, 1'b0, '0, 1'b0,
                    idle_pct);
        end else begin
          send_item(lpf_pkg::FUNC_TICK, 1'($urandom_range(1)), 8'($urandom_range(255)),
                    1'b0, '0, 1'b0, idle_pct);
        end
      end
    end

    wait_drained();
    stall_pct = 0;
    repeat (40) @(posedge clk);
    $display("Checked %0d result beats from %0d level and %0d tick items over %0d phases,",
             beat_count, level_count, tick_count, PHASES);
    $display("with fade lengths from 0 to 65535, both polarities and %0d completed fades.",
             fade_ends);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches", errors);
      $display("FAIL");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/lpf_pkg.sv
rtl/core/lpf_muldiv.sv
rtl/core/led_pwm_fade_controller_unit.sv
rtl/core/lpf_checker.sv
tb/testbench.sv
